FILE: sv/msfc_pkg.sv
package msfc_pkg;

  // field widths
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned COUNT_W = 32;

  // command codes
  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_CLEAR    = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLEAR
  } state_t;

endpackage

FILE: sv/msfc_ram.sv
module msfc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/mac_source_frame_counter_unit.sv
// Source MAC frame counter table, one command at a time: no new command is accepted while busy.
// Register command: the search reads one table entry per cycle from the address/count RAMs.
// Clear command: one used count zeroed per cycle, then the result strobe.
// The result is shown for one cycle on out_valid; the receiver cannot stall it.
// Reset (rst_n low, synchronous) empties the table; RAM contents are not cleared.
module mac_source_frame_counter_unit #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_cmd,
  input  logic [msfc_pkg::MAC_W-1:0]   in_src_mac,
  output logic                         out_valid,
  output logic [msfc_pkg::COUNT_W-1:0] out_frame_count,
  output logic                         out_table_full
);

  import msfc_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] ENTRIES_C = CW'(ENTRIES);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  state_t state_r, state_nxt;

  logic [CW-1:0]      used_r, used_nxt;
  logic [CW-1:0]      iss_r, iss_nxt;
  logic [IW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic               cmp_v_r, cmp_v_nxt;
  logic [MAC_W-1:0]   mac_r, mac_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               out_full_r, out_full_nxt;

  // RAM controls
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               addr_we;
  logic               cnt_we;
  logic [IW-1:0]      wr_addr;
  logic [COUNT_W-1:0] cnt_wdata;
  logic [MAC_W-1:0]   addr_rdata;
  logic [COUNT_W-1:0] cnt_rdata;
  logic [COUNT_W-1:0] cnt_inc;

  msfc_ram #(
    .WIDTH (MAC_W),
    .DEPTH (ENTRIES),
    .AW    (IW)
  ) u_addr_ram (
    .clk   (clk),
    .we    (addr_we),
    .waddr (wr_addr),
    .wdata (mac_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (addr_rdata)
  );

  msfc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (ENTRIES),
    .AW    (IW)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (wr_addr),
    .wdata (cnt_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (cnt_rdata)
  );

  // saturating increment of the count read with the compared address
  assign cnt_inc = (cnt_rdata == COUNT_MAX) ? COUNT_MAX : cnt_rdata + COUNT_W'(1);

  // state register and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    iss_r       <= iss_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    mac_r       <= mac_nxt;
    out_count_r <= out_count_nxt;
    out_full_r  <= out_full_nxt;
  end

  // next state, RAM access and result
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    iss_nxt       = iss_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_v_nxt     = 1'b0;
    mac_nxt       = mac_r;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;
    out_full_nxt  = out_full_r;
    rd_en         = 1'b0;
    rd_addr       = iss_r[IW-1:0];
    addr_we       = 1'b0;
    cnt_we        = 1'b0;
    wr_addr       = iss_r[IW-1:0];
    cnt_wdata     = '0;

    case (state_r)
      ST_IDLE: begin
        iss_nxt = '0;
        if (start) begin
          mac_nxt = in_src_mac;
          if (in_cmd == CMD_CLEAR) begin
            state_nxt = ST_CLEAR;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // issue the next entry read while comparing the previous one
        if (iss_r < used_r) begin
          rd_en       = 1'b1;
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = iss_r[IW-1:0];
          iss_nxt     = iss_r + CW'(1);
        end
        if (cmp_v_r && (addr_rdata == mac_r)) begin
          // hit: write back incremented count
          cnt_we        = 1'b1;
          wr_addr       = cmp_idx_r;
          cnt_wdata     = cnt_inc;
          out_valid_nxt = 1'b1;
          out_count_nxt = cnt_inc;
          out_full_nxt  = 1'b0;
          cmp_v_nxt     = 1'b0;
          state_nxt     = ST_IDLE;
        end else if (!cmp_v_r && (iss_r == used_r)) begin
          // miss: append if room is left
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          wr_addr       = used_r[IW-1:0];
          if (used_r < ENTRIES_C) begin
            addr_we       = 1'b1;
            cnt_we        = 1'b1;
            cnt_wdata     = COUNT_W'(1);
            used_nxt      = used_r + CW'(1);
            out_count_nxt = COUNT_W'(1);
            out_full_nxt  = 1'b0;
          end else begin
            out_count_nxt = '0;
            out_full_nxt  = 1'b1;
          end
        end
      end

      ST_CLEAR: begin
        // zero one used count per cycle
        if (iss_r < used_r) begin
          cnt_we    = 1'b1;
          cnt_wdata = '0;
          iss_nxt   = iss_r + CW'(1);
        end else begin
          out_valid_nxt = 1'b1;
          out_count_nxt = '0;
          out_full_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_frame_count = out_count_r;
  assign out_table_full  = out_full_r;

endmodule

FILE: tb/msfc_checker.sv
`timescale 1ns / 1ps

// Watches the command and result channels of the frame counter table and
// keeps its own copy of the address/count table to predict each result.
module msfc_checker #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         in_cmd,
  input  logic [msfc_pkg::MAC_W-1:0]   in_src_mac,
  input  logic                         out_valid,
  input  logic [msfc_pkg::COUNT_W-1:0] out_frame_count,
  input  logic                         out_table_full,
  output int unsigned                  mismatches,
  output int unsigned                  outstanding
);
  import msfc_pkg::*;

  typedef struct packed {
    logic [COUNT_W-1:0] frame_count;
    logic               table_full;
  } tally_t;

  // shadow table, filled in order of first appearance
  logic [MAC_W-1:0]   mac_table   [ENTRIES];
  logic [COUNT_W-1:0] tally_table [ENTRIES];
  int unsigned        macs_used;
  tally_t             expected_tallies [$];
  int unsigned        err_cnt;

  // apply one command word to the shadow table, return the result it causes
  function automatic tally_t tally_frame(logic cmd, logic [MAC_W-1:0] mac);
    tally_t res;
    res = '0;
    if (cmd == CMD_CLEAR) begin
      // counts go to zero, addresses and fill level stay
      for (int i = 0; i < macs_used; i++) tally_table[i] = '0;
      return res;
    end
    for (int i = 0; i < macs_used; i++) begin
      if (mac_table[i] == mac) begin
        // saturate at all ones
        if (tally_table[i] != '1) tally_table[i] = tally_table[i] + 1'b1;
        res.frame_count = tally_table[i];
        return res;
      end
    end
    if (macs_used < ENTRIES) begin
      mac_table[macs_used]   = mac;
      tally_table[macs_used] = 1;
      macs_used++;
      res.frame_count = 1;
    end else begin
      res.table_full = 1'b1;
    end
    return res;
  endfunction

  // compare results first, then queue the prediction for a newly accepted word
  always @(posedge clk) begin
    tally_t want;
    if (!rst_n) begin
      macs_used = 0;
      err_cnt   = 0;
      expected_tallies.delete();
    end else begin
      if (out_valid) begin
        if (expected_tallies.size() == 0) begin
          if (err_cnt < 10)
            $display("%0t: unexpected result: count=%0d full=%0b",
                     $realtime, out_frame_count, out_table_full);
          err_cnt++;
        end else begin
          want = expected_tallies.pop_front();
          if (out_frame_count !== want.frame_count || out_table_full !== want.table_full) begin
            if (err_cnt < 10)
              $display("%0t: result mismatch: expected count=%0d full=%0b, got count=%0d full=%0b",
                       $realtime, want.frame_count, want.table_full,
                       out_frame_count, out_table_full);
            err_cnt++;
          end
        end
      end
      if (start && !busy) expected_tallies.push_back(tally_frame(in_cmd, in_src_mac));
    end
    mismatches  <= err_cnt;
    outstanding <= expected_tallies.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import msfc_pkg::*;

  localparam int unsigned ENTRIES      = 64;
  localparam int unsigned RANDOM_WORDS = 1635;
  localparam int unsigned TAIL_WORDS   = 200;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_cmd;
  logic [MAC_W-1:0]   in_src_mac;
  logic               out_valid;
  logic [COUNT_W-1:0] out_frame_count;
  logic               out_table_full;
  int unsigned        mismatches;
  int unsigned        outstanding;

  mac_source_frame_counter_unit #(.ENTRIES(ENTRIES)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_src_mac      (in_src_mac),
    .out_valid       (out_valid),
    .out_frame_count (out_frame_count),
    .out_table_full  (out_table_full)
  );

  msfc_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_src_mac      (in_src_mac),
    .out_valid       (out_valid),
    .out_frame_count (out_frame_count),
    .out_table_full  (out_table_full),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("mac_source_frame_counter_unit test failed");
    $finish;
  end

  function automatic logic [MAC_W-1:0] random_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // present one word at the falling edge, hold it until accepted
  task automatic send_word(logic cmd, logic [MAC_W-1:0] mac);
    start      = 1'b1;
    in_cmd     = cmd;
    in_src_mac = mac;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  initial begin
    logic [MAC_W-1:0] mac;
    logic [MAC_W-1:0] learned [$];
    int unsigned      roll;
    int unsigned      reuse_pct;

    start      = 1'b0;
    in_cmd     = CMD_REGISTER;
    in_src_mac = '0;
    rst_n      = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extreme addresses, repeat matches, clears, match after clear.
    // Count saturation needs 2^32 frames on one address, out of reach here.
    send_word(CMD_REGISTER, '0);
    send_word(CMD_REGISTER, '1);
    send_word(CMD_REGISTER, '0);
    send_word(CMD_REGISTER, '1);
    send_word(CMD_REGISTER, 48'h0000_0000_0001);
    send_word(CMD_REGISTER, 48'h8000_0000_0000);
    send_word(CMD_REGISTER, 48'h7FFF_FFFF_FFFF);
    send_word(CMD_REGISTER, 48'hFFFF_FFFF_FFFE);
    send_word(CMD_CLEAR, '1);
    send_word(CMD_REGISTER, '0);
    send_word(CMD_REGISTER, '1);
    send_word(CMD_CLEAR, '0);
    send_word(CMD_CLEAR, random_mac());
    send_word(CMD_REGISTER, 48'h8000_0000_0000);
    send_word(CMD_REGISTER, 48'h0000_0000_0001);
    send_word(CMD_REGISTER, 48'h8000_0000_0000);
    learned = '{48'h0, '1, 48'h0000_0000_0001, 48'h8000_0000_0000,
                48'h7FFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFE};

    // random: mostly repeat sources, slow fill so both the partly used and
    // the full table see plenty of traffic; near misses stress the compare
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n < RANDOM_WORDS - TAIL_WORDS && (n / 80) % 3 != 2 &&
          $urandom_range(0, 3) == 0) begin
        start = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      roll      = $urandom_range(0, 99);
      reuse_pct = (learned.size() < ENTRIES) ? 90 : 75;
      if (roll < 4) begin
        send_word(CMD_CLEAR, random_mac());
      end else if (roll < reuse_pct) begin
        send_word(CMD_REGISTER, learned[$urandom_range(0, learned.size() - 1)]);
      end else begin
        mac = random_mac();
        if ($urandom_range(0, 2) == 0)
          mac = learned[$urandom_range(0, learned.size() - 1)] ^
                (48'd1 << $urandom_range(0, MAC_W - 1));
        if (learned.size() < ENTRIES) learned.push_back(mac);
        send_word(CMD_REGISTER, mac);
      end
    end
    start = 1'b0;

    // drain, then watch for stray results before the verdict
    while (outstanding != 0) @(posedge clk);
    repeat (ENTRIES + 16) @(posedge clk);
    if (mismatches == 0)
      $display("mac_source_frame_counter_unit test passed");
    else
      $display("mac_source_frame_counter_unit test failed");
    $finish;
  end

endmodule

FILE: filelist.f
sv/msfc_pkg.sv
sv/msfc_ram.sv
sv/mac_source_frame_counter_unit.sv
tb/msfc_checker.sv
tb/tb.sv
